// ===== sv/exp_pkg.sv =====
`default_nettype none
package exp_pkg;

  localparam int unsigned MaxTermsDefault = 16;
  localparam int unsigned XW = 20;
  localparam int unsigned NW = 5;
  localparam int unsigned SumW = 32;
  localparam int unsigned TermW = 26;
  localparam int unsigned ProdW = XW + TermW;
  localparam logic signed [TermW-1:0] OneQ16 = TermW'(65536);
  localparam logic signed [SumW+1:0] SumMax = 34'sh0_7FFF_FFFF;
  localparam logic signed [SumW+1:0] SumMin = -34'sh0_8000_0000;

  // Per-item state carried down the pipeline.
  typedef struct packed {
    logic signed [XW-1:0]    x;
    logic [NW:0]             n;
    logic signed [TermW-1:0] term;
    logic signed [SumW-1:0]  sum;
  } lane_t;

endpackage
`default_nettype wire

// ===== sv/exp_taylor_series_sum.sv =====
`default_nettype none
// Partial Maclaurin sum of e^x: x_value is signed Q4.16, term_count gives the
// number of terms (clipped to MAX_TERMS, zero gives zero) and series_sum is
// signed Q16.16, saturated. Each term index has its own pipeline step of three
// register levels (multiply, reciprocal divide, saturating add) behind an entry
// register; one item is taken every cycle, and a stall on the output freezes
// the whole pipeline.
module exp_taylor_series_sum #(
  parameter int unsigned MAX_TERMS = exp_pkg::MaxTermsDefault
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [exp_pkg::XW-1:0]     in_x_value,
  input  wire logic [exp_pkg::NW-1:0]            in_term_count,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [exp_pkg::SumW-1:0]        out_series_sum
);

  localparam int unsigned NS = (MAX_TERMS > 1) ? MAX_TERMS - 1 : 1;

  logic adv;
  logic [NS:0] v;
  exp_pkg::lane_t d [NS+1];
  logic v0_r;
  exp_pkg::lane_t d0_r;
  exp_pkg::lane_t head;
  logic [exp_pkg::NW:0] n_clip;

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // Entry stage: clip the count and seed term and sum.
  always_comb begin
    n_clip = ({1'b0, in_term_count} > 6'(MAX_TERMS)) ? 6'(MAX_TERMS)
                                                      : {1'b0, in_term_count};
    head.x = in_x_value;
    head.n = n_clip;
    head.term = exp_pkg::OneQ16;
    head.sum = (n_clip != '0) ? exp_pkg::SumW'(65536) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) v0_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) d0_r <= head;
  end

  assign v[0] = v0_r;
  assign d[0] = d0_r;

  for (genvar g = 0; g < NS; g++) begin : g_step
    exp_stage #(.IDX(g + 1)) u_step (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .in_v(v[g]), .in_d(d[g]),
      .out_v(v[g+1]), .out_d(d[g+1])
    );
  end

  assign out_valid = v[NS];
  assign out_series_sum = d[NS].sum;

  // An unready output must hold its item.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_series_sum))
    else $error("output changed under stall");
  // Zero-term items produce zero.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && d[NS].n == '0 |-> out_series_sum == '0)
    else $error("zero count gave nonzero sum");
  // Counts never exceed the limit inside the pipeline.
  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    v0_r |-> d0_r.n <= 6'(MAX_TERMS))
    else $error("count not clipped");

endmodule
`default_nettype wire

// ===== sv/exp_stage.sv =====
`default_nettype none
// One term step: multiply the previous term by x, then divide by 2^16 * IDX with
// truncation toward zero, then add with saturation. Three register levels.
module exp_stage #(
  parameter int unsigned IDX = 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire logic           in_v,
  input  wire exp_pkg::lane_t in_d,
  output logic                out_v,
  output exp_pkg::lane_t      out_d
);

  localparam int unsigned PW = exp_pkg::ProdW;
  // Magnitude after the 2^16 shift fits well under 31 bits.
  localparam int unsigned MW = PW - 16;
  localparam int unsigned RW = 31;
  localparam logic [MW-1:0] Idx = MW'(IDX);
  localparam logic [RW-1:0] RecipSmall = RW'((64'h1 << 30) / IDX);

  // Level 1: the term product.
  logic v1_r;
  exp_pkg::lane_t d1_r;
  logic signed [PW-1:0] p1_r;

  // Level 2: the quotient magnitude estimate.
  logic v2_r;
  exp_pkg::lane_t d2_r;
  logic neg2_r;
  logic [MW-1:0] mag2_r;
  logic [MW-1:0] q2_r;

  // Level 3: the new term and sum.
  logic v3_r;
  exp_pkg::lane_t d3_r;

  logic [PW-1:0] abs_p;
  logic [MW-1:0] mag_nxt;
  logic [MW+RW-1:0] qprod;
  logic [MW-1:0] q_nxt;
  logic [MW-1:0] rem;
  logic [MW-1:0] qfix;
  logic signed [exp_pkg::TermW-1:0] term_nxt;
  logic signed [exp_pkg::SumW+1:0] s_wide;
  logic signed [exp_pkg::SumW-1:0] sum_nxt;
  exp_pkg::lane_t d3_nxt;
  logic active;

  // Magnitude of the scaled product and its reciprocal-based quotient estimate.
  always_comb begin
    abs_p = p1_r[PW-1] ? PW'(-p1_r) : PW'(p1_r);
    mag_nxt = abs_p[PW-1:16];
    // The reciprocal is rounded down, so the estimate is the true quotient or
    // one below it.
    qprod = (MW+RW)'(mag_nxt) * (MW+RW)'(RecipSmall);
    q_nxt = qprod[30 +: MW];
  end

  always_comb begin
    // A remainder of at least one divisor means the estimate fell one short.
    rem = mag2_r - MW'((2*MW)'(q2_r) * (2*MW)'(Idx));
    qfix = (rem >= Idx) ? q2_r + MW'(1) : q2_r;
    term_nxt = neg2_r ? -(exp_pkg::TermW)'(qfix) : (exp_pkg::TermW)'(qfix);
    active = d2_r.n > 6'(IDX);
    s_wide = (exp_pkg::SumW+2)'(d2_r.sum) + (exp_pkg::SumW+2)'(term_nxt);
    if (s_wide > exp_pkg::SumMax) sum_nxt = exp_pkg::SumMax[exp_pkg::SumW-1:0];
    else if (s_wide < exp_pkg::SumMin) sum_nxt = exp_pkg::SumMin[exp_pkg::SumW-1:0];
    else sum_nxt = s_wide[exp_pkg::SumW-1:0];
    d3_nxt = d2_r;
    if (active) begin
      d3_nxt.term = term_nxt;
      d3_nxt.sum = sum_nxt;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Data path.
  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r <= in_d;
      p1_r <= PW'(in_d.term) * PW'(in_d.x);
      d2_r <= d1_r;
      neg2_r <= p1_r[PW-1];
      mag2_r <= mag_nxt;
      q2_r <= q_nxt;
      d3_r <= d3_nxt;
    end
  end

  assign out_v = v3_r;
  assign out_d = d3_r;

endmodule
`default_nettype wire
